/* rtl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes of the periodic timer table: operation, kind and
// status codes, the table entry layout, the result layout and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // Default number of table slots.
  localparam int TIMER_SLOTS_DEF = 16;

  // Operation codes.
  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_REMOVE     = 3'd1;
  localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
  localparam logic [2:0] OP_UPDATE     = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_FIRED   = 3'd1;
  localparam logic [2:0] KIND_NONE    = 3'd2;
  localparam logic [2:0] KIND_FOUND   = 3'd3;
  localparam logic [2:0] KIND_MISSING = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NULL = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [15:0] target;
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] last_fired;
  } entry_t;

  // One result word before the last flag is attached.
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] target;
    logic [31:0] id;
    logic [31:0] interval;
  } res_t;

  // Read address selection relative to the cursor.
  typedef enum logic [1:0] {
    RD_IDX   = 2'd0,
    RD_NEXT  = 2'd1,
    RD_NEXT2 = 2'd2
  } rd_sel_t;

  // Write source selection.
  typedef enum logic [1:0] {
    WR_ADD   = 2'd0,
    WR_FIRE  = 2'd1,
    WR_SHIFT = 2'd2
  } wr_sel_t;

  // Result to load into the hold register.
  typedef enum logic [2:0] {
    RES_DONE    = 3'd0,
    RES_NULL    = 3'd1,
    RES_FULL    = 3'd2,
    RES_FIRED   = 3'd3,
    RES_FOUND   = 3'd4,
    RES_NONE    = 3'd5,
    RES_MISSING = 3'd6
  } res_sel_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic     cap;
    logic     idx_clr;
    logic     idx_inc;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     hold_load;
    res_sel_t hold_sel;
    logic     push;
    logic     push_last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       cnt_zero;
    logic       full;
    logic       null_tgt;
    logic       match;
    logic       fire;
    logic       at_last;
    logic       shift_more;
    logic       hold_v;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table
// Ordered table of periodic timers with add, remove, remove all, find and
// update tick operations. Update fires every entry whose elapsed time is
// strictly greater than its period and reports one word per firing.
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     tdata 112 b, tuser 3 b
//   out_     master     out_tvalid / out_tready   tdata 80 b, tuser 5 b, tlast
//
// Add, remove all and unused codes complete without a table walk. Update
// walks all n stored entries; find walks at most that, stopping at the first
// match; remove walks all n without a match, or walks to the match and
// shifts the rest down. The walk is set by the single read port of the
// entry RAM, one entry a cycle unless a stalled output holds an update.
// Reset clears the fill count, the cursor and the valid flags; entries need
// no clearing pass.
// A stalled output pauses an update walk on the next firing entry.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [15:0] target, [47:16] timer_id, [79:48] interval, [111:80] now_time
  input  wire logic [111:0] in_tdata,
  // [2:0] operation
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] fired_target, [47:16] fired_id, [79:48] found_interval
  output logic [79:0]       out_tdata,
  // [2:0] kind, [4:3] status
  output logic [4:0]        out_tuser,
  // last_result
  output logic              out_tlast
);

  ptt_pkg::cmd_t cmd;
  ptt_pkg::sts_t sts;

  // Operation sequencer.
  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table storage and result path.
  ptt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

/* rtl/ptt_ram.sv */
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No reset; contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/ptt_ctrl.sv */
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller of the periodic timer table. Sequences each operation: capture,
// dispatch, table walk, entry shift after a remove, and result flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire ptt_pkg::sts_t sts,
  output ptt_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = ptt_pkg::RD_IDX;
    cmd.wr_sel    = ptt_pkg::WR_ADD;
    cmd.hold_sel  = ptt_pkg::RES_DONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap     = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end

      // Operations without a walk complete here; walks start at slot zero.
      ST_EXEC: begin
        case (sts.op)
          ptt_pkg::OP_ADD: begin
            cmd.hold_load = 1'b1;
            if (sts.null_tgt) begin
              cmd.hold_sel = ptt_pkg::RES_NULL;
            end else if (sts.full) begin
              cmd.hold_sel = ptt_pkg::RES_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = ptt_pkg::WR_ADD;
              cmd.cnt_inc = 1'b1;
            end
            state_nxt = ST_FLUSH;
          end
          ptt_pkg::OP_REMOVE_ALL: begin
            cmd.cnt_clr   = 1'b1;
            cmd.hold_load = 1'b1;
            state_nxt     = ST_FLUSH;
          end
          ptt_pkg::OP_REMOVE, ptt_pkg::OP_FIND, ptt_pkg::OP_UPDATE: begin
            if (sts.cnt_zero) begin
              cmd.hold_load = 1'b1;
              if (sts.op == ptt_pkg::OP_FIND) begin
                cmd.hold_sel = ptt_pkg::RES_MISSING;
              end else if (sts.op == ptt_pkg::OP_UPDATE) begin
                cmd.hold_sel = ptt_pkg::RES_NONE;
              end
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            cmd.hold_load = 1'b1;
            state_nxt     = ST_FLUSH;
          end
        endcase
      end

      // The read data holds the entry under the cursor.
      ST_SCAN: begin
        case (sts.op)
          ptt_pkg::OP_FIND: begin
            if (sts.match) begin
              cmd.hold_load = 1'b1;
              cmd.hold_sel  = ptt_pkg::RES_FOUND;
              state_nxt     = ST_FLUSH;
            end else if (sts.at_last) begin
              cmd.hold_load = 1'b1;
              cmd.hold_sel  = ptt_pkg::RES_MISSING;
              state_nxt     = ST_FLUSH;
            end else begin
              cmd.idx_inc = 1'b1;
              cmd.rd_sel  = ptt_pkg::RD_NEXT;
            end
          end
          ptt_pkg::OP_REMOVE: begin
            if (sts.match) begin
              cmd.rd_sel = ptt_pkg::RD_NEXT;
              state_nxt  = ST_SHIFT;
            end else if (sts.at_last) begin
              cmd.hold_load = 1'b1;
              state_nxt     = ST_FLUSH;
            end else begin
              cmd.idx_inc = 1'b1;
              cmd.rd_sel  = ptt_pkg::RD_NEXT;
            end
          end
          ptt_pkg::OP_UPDATE: begin
            if (sts.fire && sts.hold_v && !sts.out_free) begin
              // Output side is full: stay on this entry.
              cmd.rd_sel = ptt_pkg::RD_IDX;
            end else begin
              if (sts.fire) begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = ptt_pkg::WR_FIRE;
                cmd.hold_load = 1'b1;
                cmd.hold_sel  = ptt_pkg::RES_FIRED;
                cmd.push      = sts.hold_v;
              end
              if (sts.at_last) begin
                if (!sts.fire && !sts.hold_v) begin
                  cmd.hold_load = 1'b1;
                  cmd.hold_sel  = ptt_pkg::RES_NONE;
                end
                state_nxt = ST_FLUSH;
              end else begin
                cmd.idx_inc = 1'b1;
                cmd.rd_sel  = ptt_pkg::RD_NEXT;
              end
            end
          end
          default: begin
            cmd.hold_load = 1'b1;
            state_nxt     = ST_FLUSH;
          end
        endcase
      end

      // Move the following entries down one slot.
      ST_SHIFT: begin
        if (sts.shift_more) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ptt_pkg::WR_SHIFT;
          cmd.rd_sel  = ptt_pkg::RD_NEXT2;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.cnt_dec   = 1'b1;
          cmd.hold_load = 1'b1;
          state_nxt     = ST_FLUSH;
        end
      end

      // Hand the final result word to the output register.
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ptt_dp.sv */
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath of the periodic timer table: operand capture, entry RAM, cursor
// and fill count, match and firing compare, result hold and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_dp #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [2:0]    in_tuser,
  input  wire logic [111:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [79:0]        out_tdata,
  output logic [4:0]         out_tuser,
  output logic               out_tlast,
  input  wire ptt_pkg::cmd_t cmd,
  output ptt_pkg::sts_t      sts
);

  localparam int IDXW = $clog2(TIMER_SLOTS);
  localparam int CNTW = $clog2(TIMER_SLOTS + 1);
  localparam int EW   = $bits(ptt_pkg::entry_t);

  // Captured operands.
  logic [2:0]  op_r;
  logic [15:0] tgt_r;
  logic [31:0] id_r;
  logic [31:0] per_r;
  logic [31:0] now_r;

  logic [IDXW-1:0] idx_r;
  logic [CNTW-1:0] cnt_r;

  ptt_pkg::res_t hold_r, hold_nxt;
  logic          hold_v_r;
  ptt_pkg::res_t out_r;
  logic          out_last_r;
  logic          out_v_r;

  ptt_pkg::entry_t rd_q, wr_d;
  logic [EW-1:0]   rd_raw;
  logic [IDXW-1:0] rd_addr, wr_addr;
  logic [31:0]     elapsed;
  logic [CNTW-1:0] idx_p1;
  logic            out_free;

  // Operand capture.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_tuser;
      tgt_r <= in_tdata[15:0];
      id_r  <= in_tdata[47:16];
      per_r <= in_tdata[79:48];
      now_r <= in_tdata[111:80];
    end
  end

  // Cursor and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDXW'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  // RAM addressing and write data.
  always_comb begin
    case (cmd.rd_sel)
      ptt_pkg::RD_NEXT:  rd_addr = idx_r + IDXW'(1);
      ptt_pkg::RD_NEXT2: rd_addr = idx_r + IDXW'(2);
      default:           rd_addr = idx_r;
    endcase
    wr_addr = idx_r;
    wr_d    = rd_q;
    case (cmd.wr_sel)
      ptt_pkg::WR_ADD: begin
        wr_addr         = cnt_r[IDXW-1:0];
        wr_d.target     = tgt_r;
        wr_d.id         = id_r;
        wr_d.period     = per_r;
        wr_d.last_fired = now_r;
      end
      ptt_pkg::WR_FIRE: begin
        wr_d.last_fired = now_r;
      end
      default: begin
        wr_d = rd_q;
      end
    endcase
  end

  ptt_ram #(
    .WIDTH (EW),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_d),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_q = ptt_pkg::entry_t'(rd_raw);

  // Status toward the controller.
  assign elapsed  = now_r - rd_q.last_fired;
  assign idx_p1   = CNTW'(idx_r) + CNTW'(1);
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    sts.op         = op_r;
    sts.cnt_zero   = (cnt_r == '0);
    sts.full       = (cnt_r == CNTW'(TIMER_SLOTS));
    sts.null_tgt   = (tgt_r == 16'd0);
    sts.match      = (rd_q.target == tgt_r) && (rd_q.id == id_r);
    sts.fire       = (elapsed > rd_q.period);
    sts.at_last    = (idx_p1 == cnt_r);
    sts.shift_more = (idx_p1 < cnt_r);
    sts.hold_v     = hold_v_r;
    sts.out_free   = out_free;
  end

  // Result word selection.
  always_comb begin
    hold_nxt = '0;
    case (cmd.hold_sel)
      ptt_pkg::RES_NULL: begin
        hold_nxt.kind   = ptt_pkg::KIND_DONE;
        hold_nxt.status = ptt_pkg::STAT_NULL;
      end
      ptt_pkg::RES_FULL: begin
        hold_nxt.kind   = ptt_pkg::KIND_DONE;
        hold_nxt.status = ptt_pkg::STAT_FULL;
      end
      ptt_pkg::RES_FIRED: begin
        hold_nxt.kind     = ptt_pkg::KIND_FIRED;
        hold_nxt.target   = rd_q.target;
        hold_nxt.id       = rd_q.id;
        hold_nxt.interval = rd_q.period;
      end
      ptt_pkg::RES_FOUND: begin
        hold_nxt.kind     = ptt_pkg::KIND_FOUND;
        hold_nxt.target   = rd_q.target;
        hold_nxt.id       = rd_q.id;
        hold_nxt.interval = rd_q.period;
      end
      ptt_pkg::RES_NONE:    hold_nxt.kind = ptt_pkg::KIND_NONE;
      ptt_pkg::RES_MISSING: hold_nxt.kind = ptt_pkg::KIND_MISSING;
      default:              hold_nxt.kind = ptt_pkg::KIND_DONE;
    endcase
  end

  // Hold register: keeps the newest result until it is known whether it is
  // the last one of the operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (cmd.hold_load) begin
      hold_v_r <= 1'b1;
    end else if (cmd.push) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_r <= hold_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.push) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r      <= hold_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.interval, out_r.id, out_r.target};
  assign out_tuser  = {out_r.status, out_r.kind};
  assign out_tlast  = out_last_r;

  // The fill count never passes the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(TIMER_SLOTS))
    else $error("timer table fill count out of range");

  // A result is moved forward only when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> out_free)
    else $error("result pushed into an occupied output register");

  // A held result is never overwritten without being moved forward.
  a_hold_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hold_load && hold_v_r) |-> cmd.push)
    else $error("held result overwritten");

endmodule

`default_nettype wire
